[rtl/poly1305_aes_mac_unit_macros.svh]
// assertion helpers shared by the poly1305-aes rtl
`ifndef POLY1305_AES_MAC_UNIT_MACROS_SVH
`define POLY1305_AES_MAC_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define PAM_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define PAM_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/pam_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pam_pkg
// Shared types, constants and aes helper functions for the poly1305-aes mac.
// ----------------------------------------------------------------------------
package pam_pkg;

  localparam int BLOCK_BYTES     = 16;
  localparam int CFG_IDX_W       = 3;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int LIMB_W          = 26;
  localparam int ALIMB_W         = 27;  // limb of h + block, top limb is widest
  localparam int RLIMB_W         = 29;  // r limb, possibly folded by five
  localparam int PROD_W          = ALIMB_W + RLIMB_W;
  localparam int COL_W           = PROD_W + 3;
  localparam int WIDE_W          = 4 * LIMB_W + COL_W;
  localparam int H_W             = 130;

  localparam logic [63:0] CLAMP_BAD_LOW  = 64'hF0000003F0000000;
  localparam logic [63:0] CLAMP_BAD_HIGH = 64'hF0000003F0000003;
  localparam logic [7:0]  AES_POLY       = 8'h1b;
  localparam logic [7:0]  RCON_FIRST     = 8'h01;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_R_LOW, CFG_R_HIGH, CFG_KEY_LOW, CFG_KEY_HIGH, CFG_NONCE_LOW, CFG_NONCE_HIGH
  } pam_cfg_idx_t;

  typedef struct packed {
    logic [H_W-1:0] blk;     // padded block incl. the 2^128 bit
    logic           absorb;
    logic           last;
  } pam_entry_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? AES_POLY : 8'h00);
  endfunction

  // next round key, byte i of the key at bits 8i+7:8i
  function automatic logic [127:0] key_expand(input logic [127:0] k, input logic [7:0] rcon);
    logic [127:0] nk;
    nk = k;
    nk[7:0]   = k[7:0]   ^ SBOX[k[111:104]] ^ rcon;
    nk[15:8]  = k[15:8]  ^ SBOX[k[119:112]];
    nk[23:16] = k[23:16] ^ SBOX[k[127:120]];
    nk[31:24] = k[31:24] ^ SBOX[k[103:96]];
    for (int i = 4; i < 16; i++) begin
      nk[8*i +: 8] = k[8*i +: 8] ^ nk[8*(i-4) +: 8];
    end
    return nk;
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic fin);
    logic [7:0] sb [16];
    logic [7:0] t  [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] res;
    for (int i = 0; i < 16; i++) begin
      sb[i] = SBOX[s[8*i +: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        t[i + 4*c] = sb[i + 4*((c + i) & 3)];
      end
    end
    if (!fin) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      res[8*i +: 8] = t[i] ^ k[8*i +: 8];
    end
    return res;
  endfunction

endpackage

[rtl/pam_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pam_if
// Valid/ready channels of the poly1305-aes mac: blocks in, tags out, config.
// ----------------------------------------------------------------------------
interface pam_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic [4:0]  byte_count;
  logic        last_block;
  modport source(output valid, block_low, block_high, byte_count, last_block, input ready);
  modport sink(input valid, block_low, block_high, byte_count, last_block, output ready);
endinterface

interface pam_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] tag_low;
  logic [63:0] tag_high;
  logic        key_error;
  modport source(output valid, tag_low, tag_high, key_error, input ready);
  modport sink(input valid, tag_low, tag_high, key_error, output ready);
endinterface

interface pam_cfg_if;
  import pam_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [63:0]          data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/pam_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pam_front
// Takes block items, pads short blocks and queues work for the back end.
// ----------------------------------------------------------------------------
module pam_front (
  pam_in_if.sink             in_ch,
  input  logic               full,
  output logic               push,
  output pam_pkg::pam_entry_t entry
);
  import pam_pkg::*;

  logic [4:0]   cnt;
  logic [127:0] blk;
  logic [127:0] padded;

  assign blk = {in_ch.block_high, in_ch.block_low};

  always_comb begin
    cnt = (in_ch.byte_count > 5'(BLOCK_BYTES)) ? 5'(BLOCK_BYTES) : in_ch.byte_count;
    for (int j = 0; j < BLOCK_BYTES; j++) begin
      if (5'(j) < cnt) begin
        padded[8*j +: 8] = blk[8*j +: 8];
      end else if (5'(j) == cnt) begin
        padded[8*j +: 8] = 8'h01;
      end else begin
        padded[8*j +: 8] = 8'h00;
      end
    end
    entry.blk    = {1'b0, (cnt == 5'(BLOCK_BYTES)), padded};
    entry.absorb = (cnt != 5'd0);
    entry.last   = in_ch.last_block;
  end

  assign in_ch.ready = !full;
  // an empty block that does not end the message leaves nothing to do
  assign push = in_ch.valid && !full && (entry.absorb || entry.last);

endmodule

[rtl/pam_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pam_fifo
// Short work queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`include "poly1305_aes_mac_unit_macros.svh"
module pam_fifo #(
  parameter int DEPTH = pam_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  pam_pkg::pam_entry_t wr_data,
  input  logic                pop,
  output pam_pkg::pam_entry_t rd_data,
  output logic                full,
  output logic                not_empty
);
  import pam_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pam_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        mem_r[wr_ptr_r] <= wr_data;
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `PAM_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH), "queue overfilled")
  `PAM_ASSERT_NXT(a_cnt_drain, clk, rst_n, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "bad drain")

endmodule

[rtl/pam_aes.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pam_aes
// Iterative aes-128 encryptor, one round and one key expansion per cycle.
// ----------------------------------------------------------------------------
module pam_aes (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [127:0] key,
  input  logic [127:0] din,
  output logic         done,
  output logic [127:0] dout
);
  import pam_pkg::*;

  logic [127:0] st_r, key_r, kn;
  logic [7:0]   rcon_r;
  logic [3:0]   rnd_r;
  logic         busy_r, done_r;

  assign kn   = key_expand(key_r, rcon_r);
  assign done = done_r;
  assign dout = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r  <= 4'd1;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        st_r   <= din ^ key;
        key_r  <= key;
        rcon_r <= RCON_FIRST;
        rnd_r  <= 4'd1;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        st_r   <= aes_round(st_r, kn, rnd_r == 4'd10);
        key_r  <= kn;
        rcon_r <= xtime(rcon_r);
        rnd_r  <= rnd_r + 4'd1;
        if (rnd_r == 4'd10) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/pam_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pam_back
// Accumulator update (h + m) * r mod 2^130-5 and tag finalization.
// ----------------------------------------------------------------------------
`include "poly1305_aes_mac_unit_macros.svh"
module pam_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  pam_pkg::pam_entry_t q_data,
  output logic                pop,
  input  logic [127:0]        r_val,
  input  logic [127:0]        aes_key,
  input  logic [127:0]        nonce,
  pam_out_if.source           out_ch
);
  import pam_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_SUM, ST_FOLD, ST_NORM, ST_FIN, ST_AES, ST_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [H_W-1:0]       h_r, h_nxt;
  logic [ALIMB_W-1:0]   a_r [5];
  logic [ALIMB_W-1:0]   a_nxt [5];
  logic [RLIMB_W-1:0]   rr_r [5];
  logic [RLIMB_W-1:0]   rr_nxt [5];
  logic [PROD_W-1:0]    prod_r [5];
  logic [PROD_W-1:0]    prod_nxt [5];
  logic [COL_W-1:0]     col_r [5];
  logic [COL_W-1:0]     col_nxt [5];
  logic [2:0]           step_r, step_nxt;
  logic                 pv_r, pv_nxt;
  logic                 last_r, last_nxt;
  logic [WIDE_W-1:0]    d_r, d_nxt;
  logic [H_W:0]         t_r, t_nxt;
  logic [127:0]         fr_r, fr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [127:0]         tag_r, tag_nxt;
  logic                 kerr_r, kerr_nxt;
  logic                 out_free, out_load, aes_start, aes_done, clamp_bad;
  logic [127:0]         aes_out;
  logic [H_W:0]         sum, g;

  pam_aes u_aes (
    .clk   (clk),
    .rst_n (rst_n),
    .start (aes_start),
    .key   (aes_key),
    .din   (nonce),
    .done  (aes_done),
    .dout  (aes_out)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign clamp_bad = ((r_val[63:0] & CLAMP_BAD_LOW) != '0) ||
                     ((r_val[127:64] & CLAMP_BAD_HIGH) != '0);
  assign sum = {1'b0, h_r} + {1'b0, q_data.blk};
  assign g   = {1'b0, h_r} + (H_W+1)'(5);

  always_comb begin
    state_nxt = state_r;
    h_nxt     = h_r;
    a_nxt     = a_r;
    rr_nxt    = rr_r;
    prod_nxt  = prod_r;
    col_nxt   = col_r;
    step_nxt  = step_r;
    pv_nxt    = pv_r;
    last_nxt  = last_r;
    d_nxt     = d_r;
    t_nxt     = t_r;
    fr_nxt    = fr_r;
    tag_nxt   = tag_r;
    kerr_nxt  = kerr_r;
    pop       = 1'b0;
    out_load  = 1'b0;
    aes_start = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop      = 1'b1;
          last_nxt = q_data.last;
          if (q_data.absorb) begin
            for (int k = 0; k < 4; k++) begin
              a_nxt[k]  = ALIMB_W'(sum[LIMB_W*k +: LIMB_W]);
              rr_nxt[k] = RLIMB_W'(r_val[LIMB_W*k +: LIMB_W]);
              col_nxt[k] = '0;
            end
            a_nxt[4]   = sum[H_W:4*LIMB_W];
            rr_nxt[4]  = RLIMB_W'(r_val[127:4*LIMB_W]);
            col_nxt[4] = '0;
            step_nxt   = '0;
            pv_nxt     = 1'b0;
            state_nxt  = ST_MUL;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_MUL: begin
        // one limb of h + m against all of r; r rotates, wrapped limbs carry the 5
        if (step_r < 3'd5) begin
          for (int k = 0; k < 5; k++) begin
            prod_nxt[k] = PROD_W'(a_r[0]) * PROD_W'(rr_r[k]);
          end
          for (int k = 0; k < 4; k++) begin
            a_nxt[k]    = a_r[k+1];
            rr_nxt[k+1] = rr_r[k];
          end
          a_nxt[4]  = '0;
          rr_nxt[0] = rr_r[4] + (rr_r[4] << 2);
          step_nxt  = step_r + 3'd1;
          pv_nxt    = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          for (int k = 0; k < 5; k++) begin
            col_nxt[k] = col_r[k] + COL_W'(prod_r[k]);
          end
          if (step_r == 3'd5) begin
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        d_nxt = WIDE_W'(col_r[0]) + (WIDE_W'(col_r[1]) << LIMB_W) +
                (WIDE_W'(col_r[2]) << (2*LIMB_W)) + (WIDE_W'(col_r[3]) << (3*LIMB_W)) +
                (WIDE_W'(col_r[4]) << (4*LIMB_W));
        state_nxt = ST_FOLD;
      end
      ST_FOLD: begin
        // 2^130 == 5 mod p
        t_nxt = (H_W+1)'(d_r[H_W-1:0]) + (H_W+1)'(d_r[WIDE_W-1:H_W]) +
                ((H_W+1)'(d_r[WIDE_W-1:H_W]) << 2);
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        h_nxt     = t_r[H_W-1:0] + (t_r[H_W] ? H_W'(5) : '0);
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (clamp_bad) begin
          if (out_free) begin
            out_load  = 1'b1;
            tag_nxt   = '0;
            kerr_nxt  = 1'b1;
            h_nxt     = '0;
            state_nxt = ST_IDLE;
          end
        end else begin
          // h < 2^130, so at most one subtraction of p
          fr_nxt    = g[H_W] ? g[127:0] : h_r[127:0];
          aes_start = 1'b1;
          state_nxt = ST_AES;
        end
      end
      ST_AES: begin
        if (aes_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          tag_nxt   = fr_r + aes_out;
          kerr_nxt  = 1'b0;
          h_nxt     = '0;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      h_r         <= '0;
      step_r      <= '0;
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      a_r         <= a_nxt;
      rr_r        <= rr_nxt;
      prod_r      <= prod_nxt;
      col_r       <= col_nxt;
      step_r      <= step_nxt;
      pv_r        <= pv_nxt;
      last_r      <= last_nxt;
      d_r         <= d_nxt;
      t_r         <= t_nxt;
      fr_r        <= fr_nxt;
      out_valid_r <= out_valid_nxt;
      tag_r       <= tag_nxt;
      kerr_r      <= kerr_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.tag_low   = tag_r[63:0];
  assign out_ch.tag_high  = tag_r[127:64];
  assign out_ch.key_error = kerr_r;

  `PAM_ASSERT_NXT(a_h_clear, clk, rst_n, out_load, h_r == '0, "accumulator not cleared")
  `PAM_ASSERT_IMP(a_kerr_zero, clk, rst_n, out_valid_r && kerr_r, tag_r == '0, "tag on key error")
  `PAM_ASSERT_IMP(a_aes_state, clk, rst_n, aes_done, state_r == ST_AES, "stray aes done")

endmodule

[rtl/poly1305_aes_mac_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly1305_aes_mac_unit
// Poly1305-AES authenticator: 16-byte blocks in, one 128-bit tag per message.
// ----------------------------------------------------------------------------
//  port      dir    payload                                         flow
//  in_ch     sink   block_low, block_high, byte_count, last_block    valid/ready
//  out_ch    source tag_low, tag_high, key_error                    valid/ready
//  cfg_ch    sink   index, data (r, aes key, nonce halves)          valid/ready
//
//  a block passes the back end in order: 5 limb-multiply steps of
//  five 27x29 multipliers, accumulate, column sum, and two fold steps.
//  a last item then adds the aes start, 10 aes rounds (one per cycle), a state
//  to see the aes done and the output state.
//  the front queue takes items while the back end works; empty non-last items
//  are dropped at the front. a stalled tag holds the back end in place.
//  synchronous active-low reset clears the accumulator and all config registers.
module poly1305_aes_mac_unit #(
  parameter int QUEUE_DEPTH = pam_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pam_in_if.sink     in_ch,
  pam_out_if.source  out_ch,
  pam_cfg_if.sink    cfg_ch
);
  import pam_pkg::*;

  logic [63:0] r_low_r, r_high_r, key_low_r, key_high_r, nonce_low_r, nonce_high_r;
  logic        push, pop, full, not_empty;
  pam_entry_t  wr_entry, rd_entry;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_low_r      <= '0;
      r_high_r     <= '0;
      key_low_r    <= '0;
      key_high_r   <= '0;
      nonce_low_r  <= '0;
      nonce_high_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_R_LOW:      r_low_r      <= cfg_ch.data;
        CFG_R_HIGH:     r_high_r     <= cfg_ch.data;
        CFG_KEY_LOW:    key_low_r    <= cfg_ch.data;
        CFG_KEY_HIGH:   key_high_r   <= cfg_ch.data;
        CFG_NONCE_LOW:  nonce_low_r  <= cfg_ch.data;
        CFG_NONCE_HIGH: nonce_high_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  pam_front u_front (
    .in_ch (in_ch),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  pam_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_data   (wr_entry),
    .pop       (pop),
    .rd_data   (rd_entry),
    .full      (full),
    .not_empty (not_empty)
  );

  pam_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (not_empty),
    .q_data  (rd_entry),
    .pop     (pop),
    .r_val   ({r_high_r, r_low_r}),
    .aes_key ({key_high_r, key_low_r}),
    .nonce   ({nonce_high_r, nonce_low_r}),
    .out_ch  (out_ch)
  );

endmodule
